### src/binpos_pkg.sv
// Shared types, constants and helpers for the BINPOS trajectory parser.
package binpos_pkg;

  localparam int ATOM_BITS  = 24;
  localparam int FRAME_BITS = 32;

  typedef logic [ATOM_BITS-1:0]  atom_t;
  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_FIRST = 3'd1,
    PH_COORD = 3'd2,
    PH_COUNT = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_BAD_MAGIC   = 3'd1,
    ERR_COUNT       = 3'd2,
    ERR_AMBIGUOUS   = 3'd3,
    ERR_FRAME_COUNT = 3'd4,
    ERR_NONFINITE   = 3'd5,
    ERR_TRUNCATED   = 3'd6
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic [31:0] coord_bits;
    logic [1:0]  axis;
    logic [23:0] atom_index;
    logic [31:0] frame_num;
    logic        stream_done;
    err_t        error_code;
  } coord_word_t;

  // "fxyz"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h66;
      2'd1:    b = 8'h78;
      2'd2:    b = 8'h79;
      default: b = 8'h7a;
    endcase
    return b;
  endfunction

endpackage

### src/binpos_trajectory_parser.sv
// Top level: BINPOS byte-stream parser with output register and skid stage.
//
//   channel      | direction | handshake                 | word
//   byte stream  | in        | byte_valid / byte_stall   | byte_word  (data_byte, last_byte)
//   coordinates  | out       | coord_valid / coord_stall | coord_word (coord_bits .. error_code)
//   atom count   | in        | atoms_we                  | atoms_wdata
//
// One byte is taken per cycle while byte_stall is low; its result, if any, is registered
// in the output register, or in the skid stage while the output is stalled. Byte decode is
// combinational. A skid stage holds one result while the output is stalled; byte_stall rises
// only when that stage is full. rst is synchronous and clears the parse state, the sticky
// error and both output stages; the atom count returns to one.
module binpos_trajectory_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  output logic                       byte_stall,
  input  binpos_pkg::byte_word_t     byte_word,
  output logic                       coord_valid,
  input  logic                       coord_stall,
  output binpos_pkg::coord_word_t    coord_word,
  input  logic                       atoms_we,
  input  logic [23:0]                atoms_wdata
);

  logic [23:0]              atoms_cfg;
  binpos_pkg::phase_t       phase, phase_next;
  logic [1:0]               byte_in_word;
  logic [23:0]              word_buffer;
  logic                     order_big;
  binpos_pkg::atom_t        atom_counter;
  logic [1:0]               axis_counter;
  binpos_pkg::frame_t       frame_counter;
  binpos_pkg::err_t         sticky_error;

  logic                     skid_valid;
  binpos_pkg::coord_word_t  skid_word;

  logic                     take;
  logic                     active;
  logic                     in_magic;
  logic                     magic_ok;
  logic                     word_end;
  logic                     is_last;
  logic [7:0]               b;
  binpos_pkg::atom_t        expected;
  logic [31:0]              exp32;
  logic [31:0]              le_word, be_word, word;
  logic                     lm, bm;
  binpos_pkg::atom_t        atom_inc;
  logic                     coord_end;
  logic                     closed;
  logic                     nonfinite;

  binpos_pkg::err_t         err;
  logic                     res_valid;
  binpos_pkg::coord_word_t  res;
  logic                     res_take;

  assign b        = byte_word.data_byte;
  assign is_last  = byte_word.last_byte;
  assign take     = byte_valid && !byte_stall;
  assign active   = (sticky_error == binpos_pkg::ERR_OK) && (phase != binpos_pkg::PH_DONE);
  assign in_magic = (phase == binpos_pkg::PH_MAGIC);
  assign magic_ok = (b == binpos_pkg::magic_byte(byte_in_word));
  assign word_end = !in_magic && (byte_in_word == 2'd3);

  assign expected = binpos_pkg::atom_t'(atoms_cfg);
  assign exp32    = 32'(expected);
  assign le_word  = {b, word_buffer};
  assign be_word  = {word_buffer[7:0], word_buffer[15:8], word_buffer[23:16], b};
  assign word     = order_big ? be_word : le_word;
  assign lm       = (le_word == exp32);
  assign bm       = (be_word == exp32);

  assign atom_inc  = atom_counter + binpos_pkg::atom_t'(1);
  assign coord_end = word_end && (phase == binpos_pkg::PH_COORD);
  // frame closes on the z word of the last atom
  assign closed    = coord_end && (axis_counter == 2'd2) &&
                     ((atom_inc == expected) || (expected == '0));
  assign nonfinite = (word[30:23] == 8'hff);

  // result decode
  always_comb begin
    err       = binpos_pkg::ERR_OK;
    res_valid = 1'b0;
    res       = '0;
    if (active) begin
      case (phase)
        binpos_pkg::PH_MAGIC: begin
          if (!magic_ok)    err = binpos_pkg::ERR_BAD_MAGIC;
          else if (is_last) err = binpos_pkg::ERR_TRUNCATED;
        end
        binpos_pkg::PH_FIRST: begin
          if (!word_end) begin
            if (is_last) err = binpos_pkg::ERR_TRUNCATED;
          end else if (expected == '0 || (!lm && !bm)) begin
            err = binpos_pkg::ERR_COUNT;
          end else if (lm && bm) begin
            err = binpos_pkg::ERR_AMBIGUOUS;
          end else if (is_last) begin
            err = binpos_pkg::ERR_TRUNCATED;
          end
        end
        binpos_pkg::PH_COUNT: begin
          if (!word_end) begin
            if (is_last) err = binpos_pkg::ERR_TRUNCATED;
          end else if (word != exp32) begin
            err = binpos_pkg::ERR_FRAME_COUNT;
          end else if (is_last) begin
            err = binpos_pkg::ERR_TRUNCATED;
          end
        end
        binpos_pkg::PH_COORD: begin
          if (!word_end) begin
            if (is_last) err = binpos_pkg::ERR_TRUNCATED;
          end else begin
            if (nonfinite)              err = binpos_pkg::ERR_NONFINITE;
            else if (is_last && !closed) err = binpos_pkg::ERR_TRUNCATED;
            res.coord_bits  = word;
            res.axis        = axis_counter;
            res.atom_index  = 24'(atom_counter);
            res.frame_num   = 32'(frame_counter);
            res.stream_done = is_last && closed;
          end
        end
        default: err = binpos_pkg::ERR_OK;
      endcase
      res.error_code = err;
      res_valid      = (err != binpos_pkg::ERR_OK) || coord_end;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (take && active) begin
      case (phase)
        binpos_pkg::PH_MAGIC: begin
          if (magic_ok && byte_in_word == 2'd3) phase_next = binpos_pkg::PH_FIRST;
        end
        binpos_pkg::PH_FIRST,
        binpos_pkg::PH_COUNT: begin
          if (word_end) phase_next = binpos_pkg::PH_COORD;
        end
        binpos_pkg::PH_COORD: begin
          if (word_end) begin
            if (err == binpos_pkg::ERR_OK && is_last) phase_next = binpos_pkg::PH_DONE;
            else if (closed)                          phase_next = binpos_pkg::PH_COUNT;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atoms_cfg <= 24'd1;
    end else if (atoms_we) begin
      atoms_cfg <= atoms_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= binpos_pkg::PH_MAGIC;
      byte_in_word  <= '0;
      word_buffer   <= '0;
      order_big     <= 1'b0;
      atom_counter  <= '0;
      axis_counter  <= '0;
      frame_counter <= '0;
      sticky_error  <= binpos_pkg::ERR_OK;
    end else if (take && active) begin
      phase        <= phase_next;
      sticky_error <= err;
      // wraps to zero at the end of each word
      byte_in_word <= byte_in_word + 2'd1;
      if (!in_magic) begin
        case (byte_in_word)
          2'd0:    word_buffer[7:0]   <= b;
          2'd1:    word_buffer[15:8]  <= b;
          2'd2:    word_buffer[23:16] <= b;
          default: word_buffer        <= '0;
        endcase
      end
      if (word_end && phase == binpos_pkg::PH_FIRST) order_big <= bm;
      if (coord_end) begin
        if (axis_counter == 2'd2) begin
          axis_counter <= '0;
          if (closed) begin
            atom_counter  <= '0;
            frame_counter <= frame_counter + binpos_pkg::frame_t'(1);
          end else begin
            atom_counter <= atom_inc;
          end
        end else begin
          axis_counter <= axis_counter + 2'd1;
        end
      end
    end
  end

  // output register and skid stage
  assign res_take   = take && res_valid;
  assign byte_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!coord_valid || !coord_stall) begin
      if (skid_valid) begin
        coord_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        coord_valid <= res_take;
      end
    end else if (res_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!coord_valid || !coord_stall) begin
      if (skid_valid)    coord_word <= skid_word;
      else if (res_take) coord_word <= res;
    end else if (res_take) begin
      skid_word <= res;
    end
  end

endmodule

### src/binpos_checker.sv
// Port-level checks for the BINPOS parser, bound to the top level.
module binpos_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    byte_stall,
  input logic                    coord_valid,
  input logic                    coord_stall,
  input binpos_pkg::coord_word_t coord_word
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    coord_valid && coord_stall |=> coord_valid && $stable(coord_word))
    else $error("coord word changed while stalled");

  // byte side only stalls while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> coord_valid)
    else $error("byte stall without pending result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !coord_valid && !byte_stall)
    else $error("output not cleared by reset");

  // an error or end of stream is the final word delivered
  a_final: assert property (@(posedge clk) disable iff (rst)
    coord_valid && !coord_stall &&
    (coord_word.error_code != binpos_pkg::ERR_OK || coord_word.stream_done)
    |=> !coord_valid)
    else $error("word delivered after final word");

  a_axis: assert property (@(posedge clk) disable iff (rst)
    coord_valid |-> coord_word.axis != 2'd3)
    else $error("axis out of range");

endmodule

bind binpos_trajectory_parser binpos_checker u_binpos_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_stall  (byte_stall),
  .coord_valid (coord_valid),
  .coord_stall (coord_stall),
  .coord_word  (coord_word)
);
